// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`endif

// ----- rtl/core/ipv6hc_pkg.sv -----
// Types and constants of the IPv6 header chain parser.
// Depends on nothing; imported by every module of the block.
package ipv6hc_pkg;
   localparam logic [7:0] T_HOP = 8'd0;
   localparam logic [7:0] T_ROUTING = 8'd43;
   localparam logic [7:0] T_FRAGMENT = 8'd44;
   localparam logic [7:0] T_ESP = 8'd50;
   localparam logic [7:0] T_AUTH = 8'd51;
   localparam logic [7:0] T_DEST = 8'd60;
   localparam logic [7:0] T_MOB = 8'd135;
   localparam logic [7:0] OPT_PAD1 = 8'd0;
   localparam logic [7:0] OPT_PADN = 8'd1;
   localparam logic [7:0] OPT_HOME = 8'd201;

   localparam logic [3:0] K_BASE = 4'd0;
   localparam logic [3:0] K_SRC_HI = 4'd1;
   localparam logic [3:0] K_SRC_LO = 4'd2;
   localparam logic [3:0] K_DST_HI = 4'd3;
   localparam logic [3:0] K_DST_LO = 4'd4;
   localparam logic [3:0] K_EXT = 4'd5;
   localparam logic [3:0] K_ROUTE = 4'd6;
   localparam logic [3:0] K_FRAG = 4'd7;
   localparam logic [3:0] K_OPT = 4'd8;
   localparam logic [3:0] K_OPT_BYTE = 4'd9;
   localparam logic [3:0] K_HOME_HI = 4'd10;
   localparam logic [3:0] K_HOME_LO = 4'd11;
   localparam logic [3:0] K_END = 4'd12;

   // One result record.
   typedef struct packed {
      logic [3:0]  rec_kind;
      logic [3:0]  version;
      logic [7:0]  traffic_class;
      logic [19:0] flow_label;
      logic [15:0] payload_length;
      logic [7:0]  hop_limit;
      logic [7:0]  code;
      logic [15:0] length;
      logic [63:0] word_value;
      logic        version_bad;
      logic        last_in_run;
   } rec_type;

   // Work for one byte: up to two records.
   typedef struct packed {
      logic    two;
      rec_type rec0;
      rec_type rec1;
   } job_type;

   localparam int JOB_W = $bits(job_type);

   function automatic logic is_ext(input logic [7:0] t);
      return t == T_HOP || t == T_ROUTING || t == T_FRAGMENT || t == T_ESP ||
             t == T_AUTH || t == T_DEST || t == T_MOB;
   endfunction

   function automatic logic is_opt_hdr(input logic [7:0] t);
      return t == T_HOP || t == T_DEST;
   endfunction
endpackage

// ----- rtl/core/ipv6hc_front.sv -----
// Front part: parses each byte and emits a job of one or two records.
// Depends on ipv6hc_pkg.
module ipv6hc_front
   import ipv6hc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [7:0]  in_byte,
   input  logic        in_first,
   output logic        job_valid,
   output job_type     job
);
   typedef enum logic [1:0] {PH_WAIT, PH_BASE, PH_HDR, PH_DONE} phase_type;
   typedef enum logic [2:0] {OP_TYPE, OP_LEN, OP_PAD, OP_DATA, OP_HOME} op_type;

   phase_type   phase_ff, phase_in;
   logic [11:0] pos_ff, pos_in;
   logic [11:0] total_ff, total_in;
   logic [7:0]  pend_ff, pend_in;
   logic [7:0]  cur_ff, cur_in;
   op_type      op_ff, op_in;
   logic [7:0]  okind_ff, okind_in;
   logic [7:0]  oleft_ff, oleft_in;
   logic [63:0] word_ff, word_in;
   logic        bad_ff, bad_in;

   rec_type     recs [2];
   logic [1:0]  n;

   function automatic rec_type mk(input logic [3:0] k, input logic [7:0] c,
                                  input logic [15:0] l, input logic [63:0] w);
      rec_type r;
      r = '0;
      r.rec_kind = k;
      r.code = c;
      r.length = l;
      r.word_value = w;
      return r;
   endfunction

   // Parse one byte
   always_comb begin
      phase_type   ph;
      logic [11:0] p;
      logic [63:0] w;
      logic [7:0]  t;
      ph = phase_ff; p = pos_ff; total_in = total_ff; pend_in = pend_ff;
      cur_in = cur_ff; op_in = op_ff; okind_in = okind_ff; oleft_in = oleft_ff;
      word_in = word_ff; bad_in = bad_ff;
      recs[0] = '0; recs[1] = '0; n = 2'd0;
      t = cur_ff;
      w = '0;
      if (in_first) begin
         ph = PH_BASE; p = '0; total_in = '0; pend_in = '0; cur_in = '0;
         op_in = OP_TYPE; okind_in = '0; oleft_in = '0; word_in = '0; bad_in = 1'b0;
         t = '0;
      end
      pos_in = p;
      phase_in = ph;
      if (ph == PH_BASE) begin
         w = {word_in[55:0], in_byte};
         word_in = w;
         if (p == 12'd0) bad_in = (in_byte[7:4] != 4'd6);
         if (p == 12'd6) pend_in = in_byte;
         if (p == 12'd7) begin
            recs[0] = mk(K_BASE, w[15:8], 16'd0, 64'd0);
            recs[0].version = w[63:60];
            recs[0].traffic_class = w[59:52];
            recs[0].flow_label = w[51:32];
            recs[0].payload_length = w[31:16];
            recs[0].hop_limit = w[7:0];
            recs[0].version_bad = bad_in;
            n = 2'd1;
            word_in = '0;
         end else if (p == 12'd15 || p == 12'd23 || p == 12'd31 || p == 12'd39) begin
            recs[0] = mk(4'((p - 12'd7) >> 3), 8'd0, 16'd0, w);
            n = 2'd1;
            word_in = '0;
         end
         pos_in = p + 12'd1;
         if (p == 12'd39) begin
            if (is_ext(pend_in)) begin
               phase_in = PH_HDR; cur_in = pend_in; pos_in = '0;
               total_in = '0; op_in = OP_TYPE;
            end else begin
               recs[1] = mk(K_END, pend_in, 16'd0, 64'd0);
               n = 2'd2;
               phase_in = PH_DONE;
            end
         end
      end else if (ph == PH_HDR) begin
         if (p == 12'd0) begin
            pend_in = in_byte;
         end else if (p == 12'd1) begin
            total_in = (t == T_FRAGMENT) ? 12'd8 : {1'b0, in_byte, 3'b000} + 12'd8;
            recs[0] = mk(K_EXT, t, {4'd0, total_in}, 64'd0);
            n = 2'd1;
            op_in = OP_TYPE;
            word_in = '0;
         end else if (is_opt_hdr(t)) begin
            unique case (op_ff)
               OP_TYPE: begin
                  okind_in = in_byte;
                  if (in_byte == OPT_PAD1) begin
                     recs[0] = mk(K_OPT, OPT_PAD1, 16'd0, 64'd0);
                     n = 2'd1;
                  end else op_in = OP_LEN;
               end
               OP_LEN: begin
                  recs[0] = mk(K_OPT, okind_ff, {8'd0, in_byte}, 64'd0);
                  n = 2'd1;
                  oleft_in = in_byte;
                  if (okind_ff == OPT_HOME) begin
                     oleft_in = 8'd16; word_in = '0; op_in = OP_HOME;
                  end else if (in_byte == 8'd0) op_in = OP_TYPE;
                  else op_in = (okind_ff == OPT_PADN) ? OP_PAD : OP_DATA;
               end
               OP_PAD: begin
                  oleft_in = oleft_ff - 8'd1;
                  if (oleft_in == 8'd0) op_in = OP_TYPE;
               end
               OP_DATA: begin
                  recs[0] = mk(K_OPT_BYTE, okind_ff, 16'd0, {56'd0, in_byte});
                  n = 2'd1;
                  oleft_in = oleft_ff - 8'd1;
                  if (oleft_in == 8'd0) op_in = OP_TYPE;
               end
               OP_HOME: begin
                  w = {word_ff[55:0], in_byte};
                  word_in = w;
                  oleft_in = oleft_ff - 8'd1;
                  if (oleft_in == 8'd8) begin
                     recs[0] = mk(K_HOME_HI, OPT_HOME, 16'd0, w);
                     n = 2'd1; word_in = '0;
                  end else if (oleft_in == 8'd0) begin
                     recs[0] = mk(K_HOME_LO, OPT_HOME, 16'd0, w);
                     n = 2'd1; word_in = '0; op_in = OP_TYPE;
                  end
               end
               default: op_in = OP_TYPE;
            endcase
         end else if (t == T_ROUTING) begin
            if (p == 12'd2) word_in = {56'd0, in_byte};
            else if (p == 12'd3) begin
               recs[0] = mk(K_ROUTE, word_ff[7:0], {8'd0, in_byte}, 64'd0);
               n = 2'd1;
            end
         end else if (t == T_FRAGMENT) begin
            w = {word_ff[55:0], in_byte};
            word_in = w;
            if (p == 12'd7) begin
               recs[0] = mk(K_FRAG, 8'd0, {w[47:35], 3'b000}, {29'd0, w[34:0]});
               n = 2'd1;
               word_in = '0;
            end
         end
         pos_in = p + 12'd1;
         if (pos_in >= 12'd2 && pos_in >= total_in &&
             (!is_opt_hdr(t) || op_in == OP_TYPE)) begin
            if (is_ext(pend_in)) begin
               phase_in = PH_HDR; cur_in = pend_in; pos_in = '0;
               total_in = '0; op_in = OP_TYPE;
            end else begin
               if (n == 2'd0) recs[0] = mk(K_END, pend_in, 16'd0, 64'd0);
               else recs[1] = mk(K_END, pend_in, 16'd0, 64'd0);
               n = n + 2'd1;
               phase_in = PH_DONE;
            end
         end
      end
      // Mark the last record of the byte
      recs[0].last_in_run = (n == 2'd1);
      recs[1].last_in_run = 1'b1;
   end

   // Hold parse state, register the job
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT; pos_ff <= '0; total_ff <= '0; pend_ff <= '0;
         cur_ff <= '0; op_ff <= OP_TYPE; okind_ff <= '0; oleft_ff <= '0;
         word_ff <= '0; bad_ff <= 1'b0; job_valid <= 1'b0;
      end else begin
         job_valid <= in_valid && n != 2'd0;
         if (in_valid) begin
            phase_ff <= phase_in; pos_ff <= pos_in; total_ff <= total_in;
            pend_ff <= pend_in; cur_ff <= cur_in; op_ff <= op_in;
            okind_ff <= okind_in; oleft_ff <= oleft_in; word_ff <= word_in;
            bad_ff <= bad_in;
         end
      end
      job <= {(n == 2'd2), recs[0], recs[1]};
   end
endmodule

// ----- rtl/core/ipv6hc_queue.sv -----
// Short job queue between front and back parts.
// Depends on ipv6hc_pkg.
module ipv6hc_queue
   import ipv6hc_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    not_empty,
   output job_type head,
   output logic [$clog2(DEPTH):0] count
);
   localparam int AW = $clog2(DEPTH);
   job_type       mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   cnt_ff;

   assign not_empty = cnt_ff != '0;
   assign head = mem_ff[rd_ff];
   assign count = cnt_ff;

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (pop) rd_ff <= (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) mem_ff[wr_ff] <= push_job;
   end
endmodule

// ----- rtl/core/ipv6hc_back.sv -----
// Back part: sends the records of each job, one per cycle while out_ready allows.
// Depends on ipv6hc_pkg.
module ipv6hc_back
   import ipv6hc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    job_ready_in,
   input  job_type job,
   output logic    job_pop,
   output logic    out_valid,
   output rec_type out_rec,
   input  logic    out_ready
);
   logic second_ff;
   logic take;

   assign take = job_ready_in && (!out_valid || out_ready);
   assign job_pop = take && (!job.two || second_ff);

   // Load output register; walk the second record
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0; second_ff <= 1'b0;
      end else begin
         if (take) begin
            out_valid <= 1'b1;
            second_ff <= job.two && !second_ff;
         end else if (out_ready) out_valid <= 1'b0;
      end
      if (take) out_rec <= second_ff ? job.rec1 : job.rec0;
   end
endmodule

// ----- rtl/core/ipv6_header_chain_parser.sv -----
// Top level of the IPv6 header chain parser.
// Depends on ipv6hc_pkg, ipv6hc_front, ipv6hc_queue, ipv6hc_back, assert_macros.svh.
//
// req_ carries packet bytes in wire order, tuser marks the first byte of a packet.
// rsp_ carries parsed records: base header, address halves, extension headers,
// routing and fragment fields, options and the chain end.
// A byte is taken every cycle while the queue has room; the front parser
// handles one byte per cycle with a small state update. A byte gives zero,
// one or two records; a record passes the front's job register, the queue
// and the back part's output register, which sends a byte's two records in turn.
// The queue holds four jobs; req_tready drops once it could overflow.
// Reset clears parse state and queue; bytes before a first byte are ignored.
// When rsp_tready is low the output record holds and the queue absorbs
// jobs until it fills, then input stalls.
`include "assert_macros.svh"
module ipv6_header_chain_parser
   import ipv6hc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tuser,   // first_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rec_kind, version, traffic_class, flow_label, payload_length, hop_limit,
   // code, length, word_value, version_bad (bits 0..148), zero pad to 152
   output logic [151:0] rsp_tdata,
   output logic         rsp_tlast    // last_in_run
);
   localparam int CW = $clog2(QUEUE_DEPTH) + 1;

   logic        in_take, job_valid, q_ne, q_pop;
   job_type     job, head;
   rec_type     rec;
   logic [CW-1:0] q_cnt;

   // Leave room for the job in flight
   assign req_tready = q_cnt + CW'(job_valid) < CW'(QUEUE_DEPTH);
   assign in_take = req_tvalid && req_tready;

   ipv6hc_front u_front (
      .clock(clock), .reset(reset), .in_valid(in_take), .in_byte(req_tdata),
      .in_first(req_tuser), .job_valid(job_valid), .job(job)
   );

   ipv6hc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(job_valid), .push_job(job),
      .pop(q_pop), .not_empty(q_ne), .head(head), .count(q_cnt)
   );

   ipv6hc_back u_back (
      .clock(clock), .reset(reset), .job_ready_in(q_ne), .job(head),
      .job_pop(q_pop), .out_valid(rsp_tvalid), .out_rec(rec), .out_ready(rsp_tready)
   );

   assign rsp_tdata = {3'd0, rec.version_bad, rec.word_value, rec.length, rec.code,
                       rec.hop_limit, rec.payload_length, rec.flow_label,
                       rec.traffic_class, rec.version, rec.rec_kind};
   assign rsp_tlast = rec.last_in_run;

   `ASSERT_IMPL(a_no_overflow, clock, reset, q_cnt == CW'(QUEUE_DEPTH), !job_valid || q_pop)
   `ASSERT_IMPL(a_pop_needs_data, clock, reset, q_pop, q_ne)
   `ASSERT_ALWAYS(a_cnt_range, clock, reset, q_cnt <= CW'(QUEUE_DEPTH))
endmodule

// ----- dv/tb_ipv6_header_chain_parser.sv -----
// Testbench for the IPv6 header chain parser: directed table, then random packets.
// Depends on ipv6hc_pkg and the ipv6_header_chain_parser RTL; checks against a local predictor.
module tb_ipv6_header_chain_parser;
   import ipv6hc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_BYTES = 1700;

   typedef enum logic [1:0] {PH_WAIT, PH_BASE, PH_HDR, PH_DONE} parse_phase_type;
   typedef enum logic [2:0] {OP_TYPE, OP_LEN, OP_PAD, OP_DATA, OP_HOME} opt_phase_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'd0;   // data_byte
   logic         req_tuser = 1'b0;   // first_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // rec_kind, version, traffic_class, flow_label, payload_length, hop_limit,
   // code, length, word_value, version_bad, zero pad
   logic [151:0] rsp_tdata;
   logic         rsp_tlast;          // last_in_run

   ipv6_header_chain_parser dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Parser state mirrored by the predictor
   parse_phase_type phase;
   opt_phase_type   opt_phase;
   logic [11:0]  hdr_pos, hdr_total;
   logic [7:0]   next_hdr, cur_hdr, opt_type, opt_left;
   logic [63:0]  shift_word;
   logic         ver_bad;

   rec_type     expected_recs[$];
   rec_type     byte_recs[$];
   int          errors = 0;
   int          cycles = 0;
   int          burst_left = 0;
   int          hold_cycles = 0;
   logic [7:0]  pkt_data[$];
   logic        pkt_first[$];

   function automatic logic ext_type(input logic [7:0] t);
      case (t)
         T_HOP, T_ROUTING, T_FRAGMENT, T_ESP, T_AUTH, T_DEST, T_MOB: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic opt_carrier(input logic [7:0] t);
      return t == T_HOP || t == T_DEST;
   endfunction

   task automatic add_rec(input logic [3:0] kind, input logic [7:0] code,
                          input logic [15:0] len, input logic [63:0] word);
      rec_type r;
      r = '0;
      r.rec_kind = kind;
      r.code = code;
      r.length = len;
      r.word_value = word;
      byte_recs.push_back(r);
   endtask

   task automatic clear_parse();
      phase = PH_WAIT;
      opt_phase = OP_TYPE;
      hdr_pos = '0;
      hdr_total = '0;
      next_hdr = '0;
      cur_hdr = '0;
      opt_type = '0;
      opt_left = '0;
      shift_word = '0;
      ver_bad = 1'b0;
   endtask

   task automatic chain_step();
      if (ext_type(next_hdr)) begin
         phase = PH_HDR;
         cur_hdr = next_hdr;
         hdr_pos = '0;
         hdr_total = '0;
         opt_phase = OP_TYPE;
      end else begin
         add_rec(K_END, next_hdr, 16'd0, 64'd0);
         phase = PH_DONE;
      end
   endtask

   task automatic option_step(input logic [7:0] b);
      case (opt_phase)
         OP_TYPE: begin
            opt_type = b;
            if (b == OPT_PAD1) add_rec(K_OPT, OPT_PAD1, 16'd0, 64'd0);
            else opt_phase = OP_LEN;
         end
         OP_LEN: begin
            add_rec(K_OPT, opt_type, {8'd0, b}, 64'd0);
            opt_left = b;
            if (opt_type == OPT_HOME) begin
               opt_left = 8'd16;
               shift_word = '0;
               opt_phase = OP_HOME;
            end else if (b == 8'd0) begin
               opt_phase = OP_TYPE;
            end else begin
               opt_phase = (opt_type == OPT_PADN) ? OP_PAD : OP_DATA;
            end
         end
         OP_PAD: begin
            opt_left--;
            if (opt_left == 8'd0) opt_phase = OP_TYPE;
         end
         OP_DATA: begin
            add_rec(K_OPT_BYTE, opt_type, 16'd0, {56'd0, b});
            opt_left--;
            if (opt_left == 8'd0) opt_phase = OP_TYPE;
         end
         OP_HOME: begin
            shift_word = {shift_word[55:0], b};
            opt_left--;
            if (opt_left == 8'd8) begin
               add_rec(K_HOME_HI, OPT_HOME, 16'd0, shift_word);
               shift_word = '0;
            end else if (opt_left == 8'd0) begin
               add_rec(K_HOME_LO, OPT_HOME, 16'd0, shift_word);
               shift_word = '0;
               opt_phase = OP_TYPE;
            end
         end
         default: opt_phase = OP_TYPE;
      endcase
   endtask

   // Compute the records one accepted byte causes and queue them
   task automatic parse_byte(input logic first, input logic [7:0] b);
      logic [11:0] pos;
      logic [7:0]  t;
      rec_type     r;
      byte_recs.delete();
      if (first) begin
         clear_parse();
         phase = PH_BASE;
      end
      if (phase == PH_BASE) begin
         pos = hdr_pos;
         shift_word = {shift_word[55:0], b};
         if (pos == 12'd0) ver_bad = (b[7:4] != 4'd6);
         if (pos == 12'd6) next_hdr = b;
         if (pos == 12'd7) begin
            r = '0;
            r.rec_kind = K_BASE;
            r.version = shift_word[63:60];
            r.traffic_class = shift_word[59:52];
            r.flow_label = shift_word[51:32];
            r.payload_length = shift_word[31:16];
            r.hop_limit = shift_word[7:0];
            r.code = shift_word[15:8];
            r.version_bad = ver_bad;
            byte_recs.push_back(r);
            shift_word = '0;
         end else if (pos == 12'd15 || pos == 12'd23 || pos == 12'd31 || pos == 12'd39) begin
            add_rec(4'((pos - 12'd7) / 12'd8), 8'd0, 16'd0, shift_word);
            shift_word = '0;
         end
         hdr_pos = pos + 12'd1;
         if (pos == 12'd39) chain_step();
      end else if (phase == PH_HDR) begin
         t = cur_hdr;
         pos = hdr_pos;
         if (pos == 12'd0) begin
            next_hdr = b;
         end else if (pos == 12'd1) begin
            hdr_total = (t == T_FRAGMENT) ? 12'd8 : {1'b0, b, 3'd0} + 12'd8;
            add_rec(K_EXT, t, {4'd0, hdr_total}, 64'd0);
            opt_phase = OP_TYPE;
            shift_word = '0;
         end else if (opt_carrier(t)) begin
            option_step(b);
         end else if (t == T_ROUTING) begin
            if (pos == 12'd2) shift_word = {56'd0, b};
            else if (pos == 12'd3) add_rec(K_ROUTE, shift_word[7:0], {8'd0, b}, 64'd0);
         end else if (t == T_FRAGMENT) begin
            shift_word = {shift_word[55:0], b};
            if (pos == 12'd7) begin
               add_rec(K_FRAG, 8'd0, {shift_word[47:35], 3'd0},
                       {29'd0, shift_word[34:0]});
               shift_word = '0;
            end
         end
         pos = pos + 12'd1;
         hdr_pos = pos;
         if (pos >= 12'd2 && pos >= hdr_total && (!opt_carrier(t) || opt_phase == OP_TYPE))
            chain_step();
      end
      if (byte_recs.size() > 0) byte_recs[byte_recs.size() - 1].last_in_run = 1'b1;
      foreach (byte_recs[i]) expected_recs.push_back(byte_recs[i]);
   endtask

   // Offer one byte in bursts with gaps; return after the accepting edge
   task automatic send_byte(input logic first, input logic [7:0] b);
      logic acc;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= first;
      do begin
         @(negedge clock);
         acc = req_tready;
         @(posedge clock);
      end while (!acc);
      parse_byte(first, b);
   endtask

   task automatic push_pkt(input logic first, input logic [7:0] b);
      pkt_first.push_back(first);
      pkt_data.push_back(b);
   endtask

   // Build one packet with a random extension chain; not every packet is well-formed
   task automatic build_packet();
      logic [7:0] types[$];
      logic [7:0] t, nh, len;
      int n, total, pos, olen, sel;
      pkt_first.delete();
      pkt_data.delete();
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 6);
         case (sel)
            0: types.push_back(T_HOP);
            1: types.push_back(T_ROUTING);
            2: types.push_back(T_FRAGMENT);
            3: types.push_back(T_ESP);
            4: types.push_back(T_AUTH);
            5: types.push_back(T_DEST);
            default: types.push_back(T_MOB);
         endcase
      end
      do t = 8'($urandom()); while (ext_type(t));
      types.push_back(t);
      // Base header
      push_pkt(1'b1, ($urandom_range(0, 9) == 0) ? 8'($urandom()) : {4'd6, 4'($urandom())});
      for (int i = 1; i < 40; i++)
         push_pkt(1'b0, (i == 6) ? types[0] : 8'($urandom()));
      for (int h = 0; h < n; h++) begin
         t = types[h];
         nh = types[h + 1];
         len = ($urandom_range(0, 9) == 0) ? 8'd2 : 8'($urandom_range(0, 1));
         push_pkt(1'b0, nh);
         push_pkt(1'b0, (t == T_FRAGMENT) ? 8'($urandom()) : len);
         total = (t == T_FRAGMENT) ? 8 : len * 8 + 8;
         pos = 2;
         if (opt_carrier(t)) begin
            // Whole options until the header boundary is reached or passed
            while (pos < total) begin
               sel = $urandom_range(0, 9);
               if (sel < 2) begin
                  push_pkt(1'b0, OPT_PAD1);
                  pos++;
               end else if (sel < 4) begin
                  olen = $urandom_range(0, 4);
                  push_pkt(1'b0, OPT_PADN);
                  push_pkt(1'b0, 8'(olen));
                  repeat (olen) push_pkt(1'b0, 8'($urandom()));
                  pos += 2 + olen;
               end else if (sel < 6) begin
                  olen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 16;
                  push_pkt(1'b0, OPT_HOME);
                  push_pkt(1'b0, 8'(olen));
                  repeat (16) push_pkt(1'b0, 8'($urandom()));
                  pos += 18;
               end else begin
                  olen = $urandom_range(0, 4);
                  do t = 8'($urandom()); while (t == OPT_PAD1 || t == OPT_PADN || t == OPT_HOME);
                  push_pkt(1'b0, t);
                  push_pkt(1'b0, 8'(olen));
                  repeat (olen) push_pkt(1'b0, 8'($urandom()));
                  pos += 2 + olen;
               end
               t = types[h];
            end
         end else begin
            repeat (total - 2) push_pkt(1'b0, 8'($urandom()));
         end
      end
      repeat ($urandom_range(0, 3)) push_pkt(1'b0, 8'($urandom()));
      // Cut some packets short, to be dropped by the next start
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, pkt_data.size());
         while (pkt_data.size() > n) begin
            void'(pkt_data.pop_back());
            void'(pkt_first.pop_back());
         end
      end
   endtask

   // Directed table: first flag, byte, repeat count, optional check of the last record
   typedef struct {
      logic       first;
      logic [7:0] data;
      int         reps;
      logic       chk;
      logic [3:0] kind;
      logic [7:0] code;
   } dir_row_type;

   dir_row_type dir_rows[] = '{
      '{1'b0, 8'hFF, 2, 1'b0, K_BASE, 8'd0},        // noise before any start
      '{1'b1, 8'h60, 1, 1'b0, K_BASE, 8'd0},
      '{1'b0, 8'hFF, 5, 1'b0, K_BASE, 8'd0},
      '{1'b0, T_HOP, 1, 1'b0, K_BASE, 8'd0},
      '{1'b0, 8'hFF, 1, 1'b1, K_BASE, T_HOP},
      '{1'b0, 8'h00, 32, 1'b1, K_DST_LO, 8'd0},
      '{1'b0, T_DEST, 1, 1'b0, K_BASE, 8'd0},
      '{1'b0, 8'h00, 1, 1'b1, K_EXT, T_HOP},
      '{1'b0, OPT_PAD1, 1, 1'b1, K_OPT, OPT_PAD1},
      '{1'b0, OPT_PADN, 1, 1'b0, K_BASE, 8'd0},
      '{1'b0, 8'd1, 1, 1'b1, K_OPT, OPT_PADN},
      '{1'b0, 8'hAA, 1, 1'b0, K_BASE, 8'd0},
      '{1'b0, 8'd5, 1, 1'b0, K_BASE, 8'd0},
      '{1'b0, 8'd1, 1, 1'b1, K_OPT, 8'd5},
      '{1'b0, 8'h80, 1, 1'b1, K_OPT_BYTE, 8'd5},
      '{1'b0, T_ROUTING, 1, 1'b0, K_BASE, 8'd0},
      '{1'b0, 8'd2, 1, 1'b1, K_EXT, T_DEST},
      '{1'b0, OPT_HOME, 1, 1'b0, K_BASE, 8'd0},
      '{1'b0, 8'd16, 1, 1'b1, K_OPT, OPT_HOME},
      '{1'b0, 8'h11, 8, 1'b1, K_HOME_HI, OPT_HOME},
      '{1'b0, 8'h22, 8, 1'b1, K_HOME_LO, OPT_HOME},
      '{1'b0, OPT_PADN, 1, 1'b0, K_BASE, 8'd0},
      '{1'b0, 8'd2, 1, 1'b0, K_BASE, 8'd0},
      '{1'b0, 8'h00, 2, 1'b0, K_BASE, 8'd0},
      '{1'b0, T_FRAGMENT, 1, 1'b0, K_BASE, 8'd0},
      '{1'b0, 8'h00, 1, 1'b1, K_EXT, T_ROUTING},
      '{1'b0, 8'hFF, 2, 1'b1, K_ROUTE, 8'hFF},
      '{1'b0, 8'h00, 4, 1'b0, K_BASE, 8'd0},
      '{1'b0, 8'd6, 1, 1'b0, K_BASE, 8'd0},
      '{1'b0, 8'hFF, 1, 1'b1, K_EXT, T_FRAGMENT},
      '{1'b0, 8'hFF, 6, 1'b1, K_END, 8'd6},
      '{1'b0, 8'hFF, 3, 1'b0, K_BASE, 8'd0},        // ignored after chain end
      '{1'b1, 8'hF0, 1, 1'b0, K_BASE, 8'd0},        // bad version, then dropped
      '{1'b0, 8'h00, 10, 1'b0, K_BASE, 8'd0}
   };

   // Receiver: random stall pattern, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ((cycles / 150) % 4 == 0) ? 1'b1 : ($urandom_range(0, 99) < 60);
      end
   end

   // Check each accepted record against the oldest expectation
   always @(negedge clock) begin
      rec_type act, exp_rec;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act.rec_kind = rsp_tdata[3:0];
         act.version = rsp_tdata[7:4];
         act.traffic_class = rsp_tdata[15:8];
         act.flow_label = rsp_tdata[35:16];
         act.payload_length = rsp_tdata[51:36];
         act.hop_limit = rsp_tdata[59:52];
         act.code = rsp_tdata[67:60];
         act.length = rsp_tdata[83:68];
         act.word_value = rsp_tdata[147:84];
         act.version_bad = rsp_tdata[148];
         act.last_in_run = rsp_tlast;
         if (expected_recs.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected record %h", act);
         end else begin
            exp_rec = expected_recs.pop_front();
            if (act !== exp_rec) begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %h actual %h", exp_rec, act);
            end
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[ipv6_header_chain_parser] ERROR");
         $finish;
      end
   end

   initial begin
      int sent;
      clear_parse();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part
      foreach (dir_rows[i]) begin
         for (int k = 0; k < dir_rows[i].reps; k++)
            send_byte(dir_rows[i].first, dir_rows[i].data);
         if (dir_rows[i].chk && (byte_recs.size() == 0 ||
             byte_recs[byte_recs.size() - 1].rec_kind != dir_rows[i].kind ||
             byte_recs[byte_recs.size() - 1].code != dir_rows[i].code)) begin
            errors++;
            if (errors <= 10) $display("table row %0d: expected kind %0d code %0d", i,
                                       dir_rows[i].kind, dir_rows[i].code);
         end
      end

      // Random packets, with noise between some of them
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4)) send_byte(1'b0, 8'($urandom()));
         end
         build_packet();
         foreach (pkt_data[i]) begin
            send_byte(pkt_first[i], pkt_data[i]);
            sent++;
            if (sent == 600) hold_cycles = 300;
            if (sent == 1200) begin
               // Hold the input until everything has drained
               req_tvalid <= 1'b0;
               do @(posedge clock); while (expected_recs.size() != 0);
            end
         end
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (expected_recs.size() != 0);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("[ipv6_header_chain_parser] OK");
      end else begin
         $display("[ipv6_header_chain_parser] ERROR");
      end
      $finish;
   end
endmodule

// ----- ipv6_header_chain_parser.f -----
+incdir+rtl/core
rtl/core/ipv6hc_pkg.sv
rtl/core/ipv6hc_front.sv
rtl/core/ipv6hc_queue.sv
rtl/core/ipv6hc_back.sv
rtl/core/ipv6_header_chain_parser.sv
dv/tb_ipv6_header_chain_parser.sv
